@@ rtl/core/bfcfl_pkg.sv @@
package bfcfl_pkg;

  // Size of the slot store and the widths that follow from it.
  localparam int unsigned MAX_BLOCKS = 64;
  localparam int unsigned SLOT_W     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_BLOCKS + 1);

  // Fixed payload widths.
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned LEN_W    = 32;

  // Request codes.
  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_DUMP  = 2'd2
  } opcode_e;

  // Response status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

endpackage

@@ rtl/core/bfcfl_if.sv @@
// Request channel: one operation per transfer.
interface bfcfl_req_if;
  import bfcfl_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [ADDR_W-1:0]   block_start;
  logic [LEN_W-1:0]    size;

  modport source (output valid, opcode, block_start, size, input ready);
  modport sink   (input valid, opcode, block_start, size, output ready);
endinterface

// Response channel: one result per transfer.
interface bfcfl_rsp_if;
  import bfcfl_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   out_addr;
  logic [LEN_W-1:0]    out_len;
  logic                last;

  modport source (output valid, status, out_addr, out_len, last, input ready);
  modport sink   (input valid, status, out_addr, out_len, last, output ready);
endinterface

@@ rtl/core/bfcfl_ram.sv @@
// Simple dual-port memory: one write port, one read port with registered data.
module bfcfl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds while the read enable is low.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/bfcfl_fit.sv @@
// Length compare and subtract unit, shared by the ring walk and the final update.
module bfcfl_fit (
  input  logic [bfcfl_pkg::LEN_W-1:0] cand_len_i,
  input  logic [bfcfl_pkg::LEN_W-1:0] req_size_i,
  input  logic [bfcfl_pkg::LEN_W-1:0] best_len_i,
  input  logic                        found_i,
  output logic                        take_o,
  output logic [bfcfl_pkg::LEN_W-1:0] remain_o
);
  import bfcfl_pkg::*;

  logic fits;
  logic smaller;

  // A candidate is taken when it fits and beats the best so far; ties keep the earlier one.
  assign fits     = (cand_len_i >= req_size_i);
  assign smaller  = (cand_len_i < best_len_i);
  assign take_o   = fits && (!found_i || smaller);

  // Length left in the candidate once the request is carved off.
  assign remain_o = cand_len_i - req_size_i;

endmodule

@@ rtl/core/best_fit_circular_free_list.sv @@
// Best-fit free list over a ring of up to MAX_BLOCKS blocks held in three slot memories
// (address, length, successor). One request is taken at a time and ready is low until its
// last result has been handed to the output register. A load on an empty ring or a full
// store answers in the load step; else it writes the slot, then links it behind the tail.
// An allocate visits every ring node and then answers from the best fit found; the walk
// visits one ring node per cycle, since each node's successor comes out of the registered
// read port of the successor memory and addresses the next read. A dump emits one block
// per cycle while the consumer keeps up; an empty ring gives a single result. Output
// stalls hold each step that passes on a result. No clearing pass runs after reset; slots
// freed by exact fits are not reused, so store full comes once MAX_BLOCKS loads succeed.
module best_fit_circular_free_list (
  input  logic  clk_i,
  input  logic  rst_ni,
  bfcfl_req_if.sink   req_i,
  bfcfl_rsp_if.source rsp_o
);
  import bfcfl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_LINK,
    S_WALK,
    S_FIN,
    S_DUMP,
    S_EMPTY
  } state_e;

  state_e              state_q;
  logic [SLOT_W-1:0]   head_q, tail_q;
  logic [CNT_W-1:0]    live_q, used_q, cnt_q;
  logic [ADDR_W-1:0]   start_q;
  logic [LEN_W-1:0]    size_q;
  logic [SLOT_W-1:0]   cur_q, prev_q;
  logic                found_q;
  logic [SLOT_W-1:0]   best_q, best_prev_q, best_next_q;
  logic [LEN_W-1:0]    best_len_q;
  logic [ADDR_W-1:0]   best_addr_q;

  logic                rsp_valid_q;
  logic [STATUS_W-1:0] rsp_status_q;
  logic [ADDR_W-1:0]   rsp_addr_q;
  logic [LEN_W-1:0]    rsp_len_q;
  logic                rsp_last_q;

  logic                req_fire;
  logic                out_free;
  logic                store_full;
  logic [SLOT_W-1:0]   slot_new;
  logic                last_node;
  logic                rsp_load;

  // Memory control.
  logic                re;
  logic [SLOT_W-1:0]   raddr, waddr;
  logic                we_addr, we_len, we_next;
  logic [LEN_W-1:0]    wd_len;
  logic [SLOT_W-1:0]   wd_next;
  logic [ADDR_W-1:0]   rd_addr;
  logic [LEN_W-1:0]    rd_len;
  logic [SLOT_W-1:0]   rd_next;

  // Shared length unit.
  logic [LEN_W-1:0]    cand_len;
  logic                take;
  logic [LEN_W-1:0]    remain;
  logic                shrink;

  assign req_fire   = req_i.valid && req_i.ready;
  assign out_free   = !rsp_valid_q || rsp_o.ready;
  assign store_full = (used_q == CNT_W'(MAX_BLOCKS));
  assign slot_new   = used_q[SLOT_W-1:0];
  assign last_node  = (cnt_q == CNT_W'(1));
  assign shrink     = (remain != '0);

  assign req_i.ready    = (state_q == S_IDLE);
  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.status   = rsp_status_q;
  assign rsp_o.out_addr = rsp_addr_q;
  assign rsp_o.out_len  = rsp_len_q;
  assign rsp_o.last     = rsp_last_q;

  // Slot memories.
  bfcfl_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_BLOCKS)) u_addr_ram (
    .clk_i   (clk_i),
    .we_i    (we_addr),
    .waddr_i (waddr),
    .wdata_i (start_q),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd_addr)
  );

  bfcfl_ram #(.WIDTH(LEN_W), .DEPTH(MAX_BLOCKS)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (we_len),
    .waddr_i (waddr),
    .wdata_i (wd_len),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd_len)
  );

  bfcfl_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_BLOCKS)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (we_next),
    .waddr_i (waddr),
    .wdata_i (wd_next),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd_next)
  );

  // The walk compares fresh memory data; the final update reuses the unit on the best length.
  assign cand_len = (state_q == S_WALK) ? rd_len : best_len_q;

  bfcfl_fit u_fit (
    .cand_len_i (cand_len),
    .req_size_i (size_q),
    .best_len_i (best_len_q),
    .found_i    (found_q),
    .take_o     (take),
    .remain_o   (remain)
  );

  // Memory reads and writes for each step of the sequencer, and when a result is produced.
  always_comb begin
    re       = 1'b0;
    raddr    = rd_next;
    we_addr  = 1'b0;
    we_len   = 1'b0;
    we_next  = 1'b0;
    waddr    = slot_new;
    wd_len   = size_q;
    wd_next  = head_q;
    rsp_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (req_fire && ((opcode_e'(req_i.opcode) == OP_ALLOC) ||
                         (opcode_e'(req_i.opcode) == OP_DUMP))) begin
          re    = 1'b1;
          raddr = head_q;
        end
      end
      S_LOAD: begin
        if (!store_full) begin
          we_addr = 1'b1;
          we_len  = 1'b1;
          we_next = 1'b1;
          wd_next = (live_q == '0) ? slot_new : head_q;
        end
        rsp_load = out_free && (store_full || (live_q == '0));
      end
      S_LINK: begin
        we_next  = 1'b1;
        waddr    = tail_q;
        wd_next  = slot_new;
        rsp_load = out_free;
      end
      S_WALK: begin
        re = 1'b1;
      end
      S_FIN: begin
        if (out_free && found_q) begin
          if (shrink) begin
            we_len = 1'b1;
            waddr  = best_q;
            wd_len = remain;
          end else begin
            we_next = 1'b1;
            waddr   = best_prev_q;
            wd_next = best_next_q;
          end
        end
        rsp_load = out_free;
      end
      S_DUMP: begin
        re       = out_free;
        rsp_load = out_free;
      end
      S_EMPTY: begin
        re       = 1'b0;
        rsp_load = out_free;
      end
    endcase
  end

  // Sequencer, ring pointers and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      live_q      <= '0;
      used_q      <= '0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            start_q <= req_i.block_start;
            size_q  <= req_i.size;
            cur_q   <= head_q;
            prev_q  <= tail_q;
            cnt_q   <= live_q;
            found_q <= 1'b0;
            case (opcode_e'(req_i.opcode))
              OP_LOAD:  state_q <= S_LOAD;
              OP_ALLOC: state_q <= (live_q == '0) ? S_EMPTY : S_WALK;
              OP_DUMP:  state_q <= (live_q == '0) ? S_EMPTY : S_DUMP;
              default:  state_q <= S_IDLE;
            endcase
          end
        end
        S_LOAD: begin
          if (!store_full && (live_q != '0)) begin
            state_q <= S_LINK;
          end else if (out_free) begin
            if (!store_full) begin
              head_q <= slot_new;
              tail_q <= slot_new;
              live_q <= live_q + CNT_W'(1);
              used_q <= used_q + CNT_W'(1);
            end
            rsp_status_q <= store_full ? ST_FULL : ST_OK;
            rsp_addr_q   <= '0;
            rsp_len_q    <= '0;
            rsp_last_q   <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
        S_LINK: begin
          if (out_free) begin
            tail_q       <= slot_new;
            live_q       <= live_q + CNT_W'(1);
            used_q       <= used_q + CNT_W'(1);
            rsp_status_q <= ST_OK;
            rsp_addr_q   <= '0;
            rsp_len_q    <= '0;
            rsp_last_q   <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
        S_WALK: begin
          // The read data belongs to the node in cur_q.
          if (take) begin
            found_q     <= 1'b1;
            best_q      <= cur_q;
            best_prev_q <= prev_q;
            best_len_q  <= rd_len;
            best_addr_q <= rd_addr;
            best_next_q <= rd_next;
          end
          prev_q <= cur_q;
          cur_q  <= rd_next;
          cnt_q  <= cnt_q - CNT_W'(1);
          if (last_node) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            rsp_last_q  <= 1'b1;
            if (found_q) begin
              tail_q       <= best_prev_q;
              head_q       <= shrink ? best_q : best_next_q;
              if (!shrink) begin
                live_q <= live_q - CNT_W'(1);
              end
              rsp_status_q <= ST_OK;
              rsp_addr_q   <= best_addr_q;
              rsp_len_q    <= remain;
            end else begin
              rsp_status_q <= ST_NOFIT;
              rsp_addr_q   <= '0;
              rsp_len_q    <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        S_DUMP: begin
          if (out_free) begin
            rsp_status_q <= ST_OK;
            rsp_addr_q   <= rd_addr;
            rsp_len_q    <= rd_len;
            rsp_last_q   <= last_node;
            cnt_q        <= cnt_q - CNT_W'(1);
            if (last_node) begin
              state_q <= S_IDLE;
            end
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            rsp_status_q <= ST_NOFIT;
            rsp_addr_q   <= '0;
            rsp_len_q    <= '0;
            rsp_last_q   <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
      endcase
    end
  end

  // The ring never holds more blocks than slots handed out.
  a_live_le_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= used_q)
    else $error("live block count exceeds used slot count");

  // Slots handed out never exceed the store.
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(MAX_BLOCKS))
    else $error("used slot count exceeds the store");

  // The walk always has at least one node left to visit.
  a_walk_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (cnt_q != '0))
    else $error("ring walk with no nodes left");

  // Only a dump produces a result that is not the last one.
  a_notlast_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_last_q) |-> (state_q == S_DUMP))
    else $error("non-final result outside a dump");

endmodule
